// ===== rtl/rcugp_pkg.sv =====
package rcugp_pkg;

    localparam int GEN_W  = 64;
    localparam int MASK_W = 64;
    localparam int REL_W  = 16;
    localparam int CPU_W  = 6;
    localparam int NCPU_W = 7;
    localparam int DATA_W = 32;
    localparam int CFG_AW = 3;

    localparam logic OP_QUIET   = 1'b0;
    localparam logic OP_ENQUEUE = 1'b1;

    localparam logic [CFG_AW-3:0] CFG_NUM_CPUS = 1'b0;

endpackage

// ===== rtl/rcu_grace_period_tracker_unit.sv =====
// Grace-period tracker: start is taken while busy is low, and each item gives exactly one
// result, shown for a single cycle with done high; the receiver cannot stall it, so it
// must take every result as it appears. From acceptance to its done pulse an item goes
// through these steps in order: the CPU's entry is read from the per-CPU memory, the
// quiescent bit is cleared and the generation advanced, and callbacks are released and
// promoted and the entry written back. A new item can be accepted in the cycle that done
// is high. The entries need no clearing pass after reset; a per-entry valid bit makes a
// never-written entry read as zero. Write num_cpus only while the block is idle.
module rcu_grace_period_tracker_unit
    import rcugp_pkg::*;
#(
    parameter int MAX_CPUS    = 64,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [CPU_W-1:0]   cpu,
    output logic               done,
    output logic [REL_W-1:0]   released_count,
    output logic               enqueue_overflow,
    output logic [GEN_W-1:0]   generation,
    output logic [MASK_W-1:0]  quiesced_mask
);

    localparam int CPU_AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    typedef struct packed {
        logic [GEN_W-1:0]       gen;
        logic [COUNT_WIDTH-1:0] cur;
        logic [COUNT_WIDTH-1:0] nxt;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GEN,
        S_LIST
    } state_t;

    state_t              state_reg;
    logic [NCPU_W-1:0]   num_cpus_reg;
    logic [MASK_W-1:0]   pending_reg;
    logic [GEN_W-1:0]    global_reg;
    logic [GEN_W-1:0]    highest_reg;
    logic                op_reg;
    logic [CPU_W-1:0]    cpu_reg;
    logic                in_range_reg;
    logic                done_reg;
    logic [REL_W-1:0]    released_reg;
    logic                overflow_reg;

    entry_t              mem [MAX_CPUS];
    entry_t              rd_data_reg;
    logic                rd_valid_reg;
    logic [MAX_CPUS-1:0] valid_reg;

    logic                accept;
    logic                cfg_wr;
    logic                cfg_sel;
    logic [CPU_AW-1:0]   rd_addr;
    logic [CPU_AW-1:0]   wr_addr;
    logic                wr_en;
    entry_t              wr_data;
    entry_t              ent;
    logic                in_range;

    logic [NCPU_W-1:0]   num_eff;
    logic [MASK_W-1:0]   full_mask;
    logic [MASK_W-1:0]   bit_sel;
    logic [MASK_W-1:0]   mask_clr;
    logic [GEN_W-1:0]    gen_inc;
    logic [GEN_W-1:0]    gen_inc2;
    logic                quiet_hit;
    logic                release_cur;
    logic [COUNT_WIDTH-1:0] cur_after;
    logic                promote;
    logic                enq_ovf;

    assign pready  = 1'b1;
    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = (paddr[CFG_AW-1:2] == CFG_NUM_CPUS);
    assign prdata  = cfg_sel ? DATA_W'(num_cpus_reg) : '0;

    assign done             = done_reg;
    assign released_count   = released_reg;
    assign enqueue_overflow = overflow_reg;
    assign generation       = global_reg;
    assign quiesced_mask    = pending_reg;

    assign in_range = ({1'b0, cpu} < NCPU_W'(MAX_CPUS));
    assign rd_addr  = cpu[CPU_AW-1:0];
    assign wr_addr  = cpu_reg[CPU_AW-1:0];

    // clamp the CPU count to the supported range
    always_comb
    begin
        if (num_cpus_reg == '0)
            num_eff = NCPU_W'(1);
        else if (num_cpus_reg > NCPU_W'(MAX_CPUS))
            num_eff = NCPU_W'(MAX_CPUS);
        else
            num_eff = num_cpus_reg;
        if (num_eff >= NCPU_W'(MASK_W))
            full_mask = '1;
        else
            full_mask = (MASK_W'(1) << num_eff) - MASK_W'(1);
    end

    assign ent       = rd_valid_reg ? rd_data_reg : '0;
    assign bit_sel   = MASK_W'(1) << cpu_reg;
    assign mask_clr  = pending_reg & ~bit_sel;
    assign gen_inc   = global_reg + GEN_W'(1);
    assign gen_inc2  = global_reg + GEN_W'(2);
    assign quiet_hit = (op_reg == OP_QUIET) && in_range_reg && ((pending_reg & bit_sel) != '0);

    assign release_cur = (op_reg == OP_QUIET) && (ent.cur != '0) && (global_reg > ent.gen);
    assign cur_after   = release_cur ? '0 : ent.cur;
    assign promote     = (op_reg == OP_QUIET) && (cur_after == '0) && (ent.nxt != '0);
    assign enq_ovf     = (op_reg == OP_ENQUEUE) && (ent.nxt == '1);

    always_comb
    begin
        wr_en       = (state_reg == S_LIST) && in_range_reg;
        wr_data.gen = promote ? gen_inc : ent.gen;
        wr_data.cur = promote ? ent.nxt : cur_after;
        if (op_reg == OP_ENQUEUE)
            wr_data.nxt = enq_ovf ? ent.nxt : ent.nxt + COUNT_WIDTH'(1);
        else
            wr_data.nxt = promote ? '0 : ent.nxt;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (accept)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (accept)
                rd_valid_reg <= in_range && valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            num_cpus_reg <= NCPU_W'(1);
            pending_reg  <= '0;
            global_reg   <= '0;
            highest_reg  <= '0;
            op_reg       <= OP_QUIET;
            cpu_reg      <= '0;
            in_range_reg <= 1'b0;
            done_reg     <= 1'b0;
            released_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr && cfg_sel)
                num_cpus_reg <= pwdata[NCPU_W-1:0];
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= operation;
                        cpu_reg      <= cpu;
                        in_range_reg <= in_range;
                        state_reg    <= S_GEN;
                    end
                end
                S_GEN:
                begin
                    // clear the bit; the last clear ends the generation
                    if (quiet_hit)
                    begin
                        pending_reg <= mask_clr;
                        if (mask_clr == '0)
                        begin
                            if (gen_inc <= highest_reg)
                            begin
                                pending_reg <= full_mask;
                                global_reg  <= gen_inc2;
                                highest_reg <= gen_inc2;
                            end
                            else
                                global_reg <= gen_inc;
                        end
                    end
                    state_reg <= S_LIST;
                end
                S_LIST:
                begin
                    // promote waiting callbacks into a generation
                    if (in_range_reg && promote)
                    begin
                        if (pending_reg != '0)
                            highest_reg <= gen_inc2;
                        else
                        begin
                            pending_reg <= full_mask;
                            global_reg  <= gen_inc;
                            highest_reg <= gen_inc;
                        end
                    end
                    released_reg <= (in_range_reg && release_cur) ? REL_W'(ent.cur) : '0;
                    overflow_reg <= in_range_reg && enq_ovf;
                    done_reg     <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== test/rcu_grace_period_tracker_unit_tb.sv =====
module rcu_grace_period_tracker_unit_tb;
    import rcugp_pkg::*;

    localparam logic [CFG_AW-1:0] NUM_CPUS_ADDR = CFG_AW'(4 * CFG_NUM_CPUS);
    localparam logic [REL_W-1:0]  COUNT_FULL    = '1;

    typedef struct packed {
        logic [REL_W-1:0]  released;
        logic              overflow;
        logic [GEN_W-1:0]  gen;
        logic [MASK_W-1:0] mask;
    } grace_result_t;

    class grace_ledger;
        logic [NCPU_W-1:0] num_cpus;
        logic [MASK_W-1:0] pend_mask;
        logic [GEN_W-1:0]  cur_gen;
        logic [GEN_W-1:0]  wanted_gen;
        logic [GEN_W-1:0]  cpu_gen [64];
        logic [REL_W-1:0]  cur_cnt [64];
        logic [REL_W-1:0]  next_cnt [64];
        grace_result_t     expected_q [$];
        int                errors;
        int                checked;
        int                overflows;
        int                releases;

        function new();
            num_cpus   = 7'd1;
            pend_mask  = '0;
            cur_gen    = '0;
            wanted_gen = '0;
            foreach (cpu_gen[i])
            begin
                cpu_gen[i]  = '0;
                cur_cnt[i]  = '0;
                next_cnt[i] = '0;
            end
            errors    = 0;
            checked   = 0;
            overflows = 0;
            releases  = 0;
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction

        function void open_generation();
            int n;
            n = (num_cpus == 0) ? 1 : ((num_cpus > 64) ? 64 : int'(num_cpus));
            pend_mask  = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
            cur_gen    = cur_gen + 64'd1;
            wanted_gen = cur_gen;
        endfunction

        function void note_item(logic op, logic [CPU_W-1:0] c);
            grace_result_t r;
            logic [MASK_W-1:0] cpu_bit;
            r = '0;
            if (op == OP_ENQUEUE)
            begin
                if (next_cnt[c] == COUNT_FULL)
                    r.overflow = 1'b1;
                else
                    next_cnt[c] = next_cnt[c] + 1'b1;
            end
            else
            begin
                cpu_bit = 64'd1 << c;
                if ((pend_mask & cpu_bit) != 0)
                begin
                    pend_mask = pend_mask & ~cpu_bit;
                    if (pend_mask == 0)
                    begin
                        cur_gen = cur_gen + 64'd1;
                        if (cur_gen <= wanted_gen)
                            open_generation();
                    end
                end
                if (cur_cnt[c] != 0 && cur_gen > cpu_gen[c])
                begin
                    r.released = cur_cnt[c];
                    cur_cnt[c] = '0;
                end
                if (cur_cnt[c] == 0 && next_cnt[c] != 0)
                begin
                    cur_cnt[c]  = next_cnt[c];
                    next_cnt[c] = '0;
                    cpu_gen[c]  = cur_gen + 64'd1;
                    if (pend_mask != 0)
                        wanted_gen = cpu_gen[c] + 64'd1;
                    else
                        open_generation();
                end
            end
            r.gen  = cur_gen;
            r.mask = pend_mask;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [REL_W-1:0] rel, logic ovf,
                                   logic [GEN_W-1:0] gen, logic [MASK_W-1:0] mask);
            grace_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: released %0d overflow %0b gen %h mask %h",
                         $time, rel, ovf, gen, mask);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (ovf)
                overflows++;
            if (rel != 0)
                releases++;
            if (rel !== want.released)
            begin
                errors++;
                $display("%0t: released_count expected %0d actual %0d",
                         $time, want.released, rel);
            end
            if (ovf !== want.overflow)
            begin
                errors++;
                $display("%0t: enqueue_overflow expected %0b actual %0b",
                         $time, want.overflow, ovf);
            end
            if (gen !== want.gen)
            begin
                errors++;
                $display("%0t: generation expected %h actual %h", $time, want.gen, gen);
            end
            if (mask !== want.mask)
            begin
                errors++;
                $display("%0t: quiesced_mask expected %h actual %h", $time, want.mask, mask);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              start;
    logic              busy;
    logic              operation;
    logic [CPU_W-1:0]  cpu;
    logic              done;
    logic [REL_W-1:0]  released_count;
    logic              enqueue_overflow;
    logic [GEN_W-1:0]  generation;
    logic [MASK_W-1:0] quiesced_mask;

    grace_ledger ledger = new();
    int          items_sent = 0;
    int          gap_odds = 0;
    int          live = 1;

    rcu_grace_period_tracker_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .cpu              (cpu),
        .done             (done),
        .released_count   (released_count),
        .enqueue_overflow (enqueue_overflow),
        .generation       (generation),
        .quiesced_mask    (quiesced_mask)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_result(released_count, enqueue_overflow, generation, quiesced_mask);
    end

    initial
    begin
        #20_000_000;
        $display("rcu_grace_period_tracker_unit_tb: errors");
        $finish;
    end

    task automatic apb_access(input logic wr, input logic [CFG_AW-1:0] a,
                              input logic [DATA_W-1:0] d, output logic [DATA_W-1:0] q);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        q = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_num_cpus(input logic [NCPU_W-1:0] v);
        logic [DATA_W-1:0] q;
        apb_access(1'b1, NUM_CPUS_ADDR, DATA_W'(v), q);
        ledger.num_cpus = v;
        live = (v == 0) ? 1 : ((v > 64) ? 64 : int'(v));
        apb_access(1'b0, NUM_CPUS_ADDR, '0, q);
        if (q[NCPU_W-1:0] !== v)
        begin
            ledger.errors++;
            $display("%0t: num_cpus readback expected %0d actual %0d", $time, v, q[NCPU_W-1:0]);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (ledger.waiting() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic send_item(input logic op, input logic [CPU_W-1:0] c);
        start     <= 1'b1;
        operation <= op;
        cpu       <= c;
        do @(posedge clk); while (busy);
        ledger.note_item(op, c);
        items_sent++;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic run_phase(input logic [NCPU_W-1:0] setting, input int quota, input int odds);
        int first;
        int k;
        int sent;
        logic op;
        drain();
        write_num_cpus(setting);
        gap_odds = odds;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                first = $urandom_range(0, live - 1);
                for (k = 0; k < live; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_item(OP_ENQUEUE, CPU_W'($urandom_range(0, live - 1)));
                        sent++;
                    end
                    if ($urandom_range(0, 19) != 0)
                    begin
                        send_item(OP_QUIET, CPU_W'((first + k) % live));
                        sent++;
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    op = ($urandom_range(0, 4) < 2) ? OP_ENQUEUE : OP_QUIET;
                    send_item(op, CPU_W'($urandom_range(0, 63)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [DATA_W-1:0] q;
        int wait_cycles;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        start     <= 1'b0;
        operation <= OP_QUIET;
        cpu       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, NUM_CPUS_ADDR, '0, q);
        if (q[NCPU_W-1:0] !== 7'd1)
        begin
            ledger.errors++;
            $display("%0t: num_cpus after reset expected 1 actual %0d", $time, q[NCPU_W-1:0]);
        end

        send_item(OP_QUIET, 6'd0);
        drain();
        write_num_cpus(7'd2);
        send_item(OP_ENQUEUE, 6'd0);
        send_item(OP_ENQUEUE, 6'd63);
        send_item(OP_ENQUEUE, 6'd1);
        send_item(OP_ENQUEUE, 6'd1);
        send_item(OP_QUIET, 6'd0);
        send_item(OP_QUIET, 6'd63);
        send_item(OP_QUIET, 6'd1);
        send_item(OP_QUIET, 6'd0);
        send_item(OP_QUIET, 6'd1);
        send_item(OP_QUIET, 6'd0);
        send_item(OP_QUIET, 6'd63);
        send_item(OP_QUIET, 6'd1);
        send_item(OP_QUIET, 6'd0);
        send_item(OP_QUIET, 6'd63);
        send_item(OP_ENQUEUE, 6'd42);
        send_item(OP_ENQUEUE, 6'd21);
        send_item(OP_QUIET, 6'd21);
        send_item(OP_QUIET, 6'd42);
        send_item(OP_QUIET, 6'd0);
        send_item(OP_QUIET, 6'd1);
        send_item(OP_QUIET, 6'd42);

        run_phase(7'd1, 150, 5);
        run_phase(7'd0, 150, 3);
        run_phase(7'd5, 150, 0);
        run_phase(7'd64, 150, 6);
        run_phase(7'd3, 150, 8);
        run_phase(7'd127, 150, 4);
        run_phase(7'd65, 150, 0);
        run_phase(7'd8, 150, 6);
        run_phase(NCPU_W'($urandom_range(9, 63)), 150, 3);
        run_phase(7'd2, 150, 5);
        run_phase(7'd4, 150, 0);

        start <= 1'b0;
        wait_cycles = 0;
        while (ledger.waiting() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);

        $display("%0d items sent, %0d results checked, %0d with overflow, %0d with a release",
                 items_sent, ledger.checked, ledger.overflows, ledger.releases);
        $display("num_cpus swept over 0, 1, 2, 3, 4, 5, 8, 64, 65, 127 and a random value");
        if (ledger.errors == 0 && ledger.waiting() == 0)
            $display("rcu_grace_period_tracker_unit_tb: clean");
        else
            $display("rcu_grace_period_tracker_unit_tb: errors");
        $finish;
    end

endmodule
